### design/tga_psd_pkg.sv
// shared constants for the tga pixel stream decoder
// image mode codes, field widths and the pixel total limit; no dependencies
package tga_psd_pkg;

   // image mode codes
   localparam logic [2:0] MODE_GREY  = 3'd0;
   localparam logic [2:0] MODE_RAW16 = 3'd1;
   localparam logic [2:0] MODE_RAW24 = 3'd2;
   localparam logic [2:0] MODE_RAW32 = 3'd3;
   localparam logic [2:0] MODE_RLE24 = 3'd4;
   localparam logic [2:0] MODE_RLE32 = 3'd5;

   // configuration register indexes
   localparam logic CSR_IMAGE_MODE  = 1'b0;
   localparam logic CSR_PIXEL_TOTAL = 1'b1;

   // widths
   localparam int INDEX_BITS = 24;
   localparam int FIRST_W    = 24;
   localparam int TOTAL_W    = 25;

   // largest pixel total the decoder honors
   localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(25'h100_0000);

   // mask applied to the reported first index
   localparam logic [FIRST_W-1:0] INDEX_MASK =
      (INDEX_BITS >= FIRST_W) ? {FIRST_W{1'b1}} : FIRST_W'((64'd1 << INDEX_BITS) - 64'd1);

endpackage

### design/tga_pixel_stream_decoder.sv
// tga pixel stream decoder top level
// depends on tga_psd_pkg for mode codes, widths and limits

// Takes the pixel-data bytes of a TGA image, one byte per item, and returns
// ARGB pixels. Every byte is decoded in a single pass of logic between the
// input handshake and one output register, so a byte is taken in every cycle
// while the output register is empty or is being emptied in the same cycle;
// the rate is one byte per clock, set by the single result register. A pixel
// appears in the cycle after its last byte is taken. RLE run packets give one result with
// a repeat count. A packet that would pass the pixel total gives an error
// result and the decoder ignores bytes until one arrives with new_image set.
// Configuration writes take effect on the next byte.
module tga_pixel_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] new_image
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] pixel, [39:32] repeat_res, [63:40] first_index
   output logic        rsp_tlast,   // last
   output logic        rsp_tuser,   // [0] error
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [tga_psd_pkg::TOTAL_W-1:0] csr_wdata
);
   import tga_psd_pkg::*;

   // configuration registers
   logic [2:0]         image_mode_ff;
   logic [TOTAL_W-1:0] pixel_total_ff;

   // decoder state
   logic [1:0]         byte_phase_ff,    byte_phase_in;
   logic [23:0]        colour_bytes_ff,  colour_bytes_in;
   logic [7:0]         packet_left_ff,   packet_left_in;
   logic               packet_is_run_ff, packet_is_run_in;
   logic               expect_header_ff, expect_header_in;
   logic [TOTAL_W-1:0] pixel_index_ff,   pixel_index_in;
   logic               halted_ff,        halted_in;

   // result register
   logic               out_valid_ff;
   logic [31:0]        out_pixel_ff,  out_pixel_in;
   logic [7:0]         out_repeat_ff, out_repeat_in;
   logic [FIRST_W-1:0] out_first_ff,  out_first_in;
   logic               out_last_ff,   out_last_in;
   logic               out_error_ff,  out_error_in;
   logic               produce;

   logic               accept;
   logic [TOTAL_W-1:0] total_now;

   // state after an optional new image clear
   logic [1:0]         cur_phase;
   logic [23:0]        cur_colour;
   logic [7:0]         cur_left;
   logic               cur_run;
   logic               cur_header;
   logic [TOTAL_W-1:0] cur_index;
   logic               cur_halted;

   // working values
   logic [7:0]         d;
   logic [2:0]         need;
   logic [8:0]         count;
   logic [TOTAL_W:0]   span_end;
   logic [15:0]        word16;
   logic [7:0]         cb, cg, cr, ca;
   logic [31:0]        pix;
   logic [7:0]         rep;
   logic [TOTAL_W-1:0] next_index;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // effective pixel total
   always_comb begin
      priority if (pixel_total_ff == '0) begin
         total_now = TOTAL_W'(1);
      end else if (pixel_total_ff > MAX_TOTAL) begin
         total_now = MAX_TOTAL;
      end else begin
         total_now = pixel_total_ff;
      end
   end

   // decode one byte
   always_comb begin
      d = req_tdata;

      if (req_tuser) begin
         cur_phase  = '0;
         cur_colour = '0;
         cur_left   = '0;
         cur_run    = 1'b0;
         cur_header = 1'b1;
         cur_index  = '0;
         cur_halted = 1'b0;
      end else begin
         cur_phase  = byte_phase_ff;
         cur_colour = colour_bytes_ff;
         cur_left   = packet_left_ff;
         cur_run    = packet_is_run_ff;
         cur_header = expect_header_ff;
         cur_index  = pixel_index_ff;
         cur_halted = halted_ff;
      end

      byte_phase_in    = cur_phase;
      colour_bytes_in  = cur_colour;
      packet_left_in   = cur_left;
      packet_is_run_in = cur_run;
      expect_header_in = cur_header;
      pixel_index_in   = cur_index;
      halted_in        = cur_halted;

      produce       = 1'b0;
      out_pixel_in  = '0;
      out_repeat_in = 8'd1;
      out_first_in  = cur_index[FIRST_W-1:0] & INDEX_MASK;
      out_last_in   = 1'b0;
      out_error_in  = 1'b0;

      // bytes per pixel of the colour modes; grey takes its pixel from one byte
      unique case (image_mode_ff)
         MODE_RAW16:             need = 3'd2;
         MODE_RAW24, MODE_RLE24: need = 3'd3;
         default:                need = 3'd4;
      endcase

      // packet header count
      if (d < 8'h80) begin
         count = {1'b0, d} + 9'd1;
      end else begin
         count = {1'b0, d} - 9'd127;
      end
      span_end = {1'b0, cur_index} + (TOTAL_W + 1)'(count);

      // pixel assembly
      word16 = {d, cur_colour[7:0]};
      cb = cur_colour[7:0];
      cg = cur_colour[15:8];
      cr = cur_colour[23:16];
      ca = d;
      if (need == 3'd3) begin
         cr = d;
         ca = 8'hFF;
      end
      if (image_mode_ff == MODE_RAW16) begin
         cb = {word16[4:0], 3'b000};
         cg = {word16[9:5], 3'b000};
         cr = {word16[14:10], 3'b000};
         ca = 8'hFF;
      end
      if (image_mode_ff == MODE_GREY) begin
         pix = {d, d, d, d};
      end else begin
         pix = {ca, cr, cg, cb};
      end

      // repeat count of the emitted result
      if (image_mode_ff >= MODE_RLE24 && cur_run) begin
         rep = cur_left;
      end else begin
         rep = 8'd1;
      end
      next_index = cur_index + TOTAL_W'(rep);

      if (!(cur_halted || image_mode_ff > MODE_RLE32)) begin
         priority if (image_mode_ff >= MODE_RLE24 && cur_header) begin
            // packet header byte
            packet_is_run_in = (d >= 8'h80);
            if (span_end > (TOTAL_W + 1)'(total_now)) begin
               halted_in     = 1'b1;
               produce       = 1'b1;
               out_repeat_in = count[7:0];
               out_error_in  = 1'b1;
            end else begin
               packet_left_in   = count[7:0];
               expect_header_in = 1'b0;
               byte_phase_in    = '0;
               colour_bytes_in  = '0;
            end
         end else if (image_mode_ff != MODE_GREY && ({1'b0, cur_phase} + 3'd1) < need) begin
            // gather a colour byte
            unique case (cur_phase)
               2'd0:    colour_bytes_in = cur_colour | {16'h0000, d};
               2'd1:    colour_bytes_in = cur_colour | {8'h00, d, 8'h00};
               2'd2:    colour_bytes_in = cur_colour | {d, 16'h0000};
               default: colour_bytes_in = cur_colour;
            endcase
            byte_phase_in = cur_phase + 2'd1;
         end else begin
            // final byte of a pixel, grey leaves the gathered bytes alone
            if (image_mode_ff != MODE_GREY) begin
               byte_phase_in   = '0;
               colour_bytes_in = '0;
            end
            if (image_mode_ff >= MODE_RLE24) begin
               if (cur_run) begin
                  packet_left_in   = '0;
                  expect_header_in = 1'b1;
               end else begin
                  packet_left_in = cur_left - 8'd1;
                  if (cur_left == 8'd1) begin
                     expect_header_in = 1'b1;
                  end
               end
            end
            pixel_index_in = next_index;
            produce        = 1'b1;
            out_pixel_in   = pix;
            out_repeat_in  = rep;
            out_last_in    = (next_index >= total_now);
            if (next_index >= total_now) begin
               halted_in = 1'b1;
            end
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_mode_ff  <= MODE_RAW32;
         pixel_total_ff <= TOTAL_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_MODE:  image_mode_ff  <= csr_wdata[2:0];
            CSR_PIXEL_TOTAL: pixel_total_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // decoder state update
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff    <= '0;
         colour_bytes_ff  <= '0;
         packet_left_ff   <= '0;
         packet_is_run_ff <= 1'b0;
         expect_header_ff <= 1'b1;
         pixel_index_ff   <= '0;
         halted_ff        <= 1'b0;
      end else if (accept) begin
         byte_phase_ff    <= byte_phase_in;
         colour_bytes_ff  <= colour_bytes_in;
         packet_left_ff   <= packet_left_in;
         packet_is_run_ff <= packet_is_run_in;
         expect_header_ff <= expect_header_in;
         pixel_index_ff   <= pixel_index_in;
         halted_ff        <= halted_in;
      end
   end

   // result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= produce;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept && produce) begin
         out_pixel_ff  <= out_pixel_in;
         out_repeat_ff <= out_repeat_in;
         out_first_ff  <= out_first_in;
         out_last_ff   <= out_last_in;
         out_error_ff  <= out_error_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_first_ff, out_repeat_ff, out_pixel_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_error_ff;

endmodule
